[design/ptg_pkg.sv]
package ptg_pkg;

   // Field and register widths
   localparam int COORD_WIDTH    = 32;
   localparam int POS_WIDTH      = 9;
   localparam int RANGE_WIDTH    = 32;
   localparam int SCALE_WIDTH    = 24;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int PRODUCT_WIDTH  = 64;

   // Register reset values
   localparam logic [RANGE_WIDTH-1:0] RANGE_LIMIT_RESET     = 32'd2949120;
   localparam logic [SCALE_WIDTH-1:0] PIXELS_PER_UNIT_RESET = 24'd279620;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_LIMIT     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXELS_PER_UNIT = 1'd1;

   // Pixel codes
   localparam logic [1:0] CODE_WHITE = 2'd0;
   localparam logic [1:0] CODE_RED   = 2'd1;
   localparam logic [1:0] CODE_BLACK = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_ROAD     = 2'd1,
      OP_BUILDING = 2'd2,
      OP_READ     = 2'd3
   } operation_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_LIM,
      ST_SCALE_X,
      ST_SCALE_Y,
      ST_MAP_Y,
      ST_MASK,
      ST_FILL,
      ST_READ,
      ST_PICK,
      ST_RESP
   } state_type;

endpackage

[design/ptg_channel_if.sv]
// Request channel: one operation per transaction
interface ptg_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [1:0]                                operation;
   logic signed [ptg_pkg::COORD_WIDTH-1:0]    point_x;
   logic signed [ptg_pkg::COORD_WIDTH-1:0]    point_y;
   logic [ptg_pkg::POS_WIDTH-1:0]             read_row;
   logic [ptg_pkg::POS_WIDTH-1:0]             read_col;

   modport source (output valid, operation, point_x, point_y, read_row, read_col,
                   input ready);
   modport sink   (input valid, operation, point_x, point_y, read_row, read_col,
                   output ready);
endinterface

// Response channel: one result per request
interface ptg_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] pixel_color;
   logic       drawn;

   modport source (output valid, pixel_color, drawn, input ready);
   modport sink   (input valid, pixel_color, drawn, output ready);
endinterface

[design/point_to_grid_rasterizer_top.sv]
// Bird's-eye point rasterizer onto a CANVAS_SIDE x CANVAS_SIDE canvas of 2-bit codes.
// req_channel carries one operation per transaction: clear, draw road point,
// draw building point or read pixel. rsp_channel returns exactly one result per
// request (pixel_color on a read, drawn on a draw), in request order.
// csr_* writes range_limit (index 0) or pixels_per_unit (index 1); write only
// while no request is outstanding.
// One request is processed at a time; req ready is high only in idle.
// Steps from accept to rsp valid, using the shared 32x32 multiplier and the
// row read-modify-write of the canvas memory (one write, one read port):
//   draw:  square x, y and range limit, scale x, scale y, map y, mask, then
//          fill the rows spanned (up to 2*half_side+1, fewer when clipped);
//          a point failing the range or bounds checks skips the fill
//   read:  memory read, pixel pick, response
//   clear: one canvas row written per cycle, then response
// The block returns to idle between transactions. After reset the same clearing
// pass runs before the first request is accepted. The result sits in an output
// register; if the receiver stalls, the block holds in its response state until
// it drains, and a request can be accepted while a previous result waits.
module point_to_grid_rasterizer_top #(
   parameter int CANVAS_SIDE        = 384,
   parameter int ROAD_HALF_SIDE     = 7,
   parameter int BUILDING_HALF_SIDE = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   ptg_req_if.sink                                req_channel,
   ptg_rsp_if.source                              rsp_channel,
   input  logic                                   csr_write_enable,
   input  logic [ptg_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ptg_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   localparam int IDXW     = $clog2(CANVAS_SIDE);
   localparam int CNTW     = $clog2(CANVAS_SIDE + 1);
   localparam int SW       = CNTW + 1;
   localparam int ROW_BITS = 2 * CANVAS_SIDE;
   localparam int MW       = 25;
   localparam int HALF     = CANVAS_SIDE / 2;

   // Configuration registers
   logic [ptg_pkg::RANGE_WIDTH-1:0] range_limit_ff;
   logic [ptg_pkg::SCALE_WIDTH-1:0] pixels_per_unit_ff;

   // Sequencer
   ptg_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0]    row_cnt_ff, row_cnt_in;
   logic [CNTW-1:0]    row_end_ff;
   logic               pend_ff, pend_in;
   logic [IDXW-1:0]    pend_row_ff;
   logic               clear_rsp_ff;
   logic               req_take;

   // Request fields held for the transaction
   ptg_pkg::operation_type            op_ff;
   logic [ptg_pkg::COORD_WIDTH-1:0]   mx_ff, my_ff;
   logic                              nx_ff, ny_ff;
   logic [ptg_pkg::COORD_WIDTH-1:0]   mag_x, mag_y;
   logic [IDXW-1:0]                   rd_row_ff, pick_col_ff;
   logic                              read_ok_ff;
   logic [1:0]                        code_ff;

   // Shared multiplier and checks
   logic [ptg_pkg::COORD_WIDTH-1:0]   mul_a, mul_b;
   logic [ptg_pkg::PRODUCT_WIDTH-1:0] prod_ff, dist_ff;
   logic                              in_range_ff;
   logic [IDXW-1:0]                   col_ff, row_ff;
   logic                              col_ok_ff, row_ok_ff;
   logic                              draw_ok;

   // Axis mapping
   logic [23:0]   map_hi;
   logic          map_frac, map_neg, map_ok;
   logic [MW-1:0] half_w, hi_w, pos_sum, map_val;

   // Square bounds and column mask
   logic [SW-1:0]          half_side, col_w, row_w, c_lo, c_hi, r_lo, r_hi;
   logic [CANVAS_SIDE-1:0] mask_ff, mask_in;

   // Canvas memory, one row per word
   logic [ROW_BITS-1:0] canvas_mem [CANVAS_SIDE];
   logic [ROW_BITS-1:0] rd_data_ff, fill_row, mem_wdata;
   logic [IDXW-1:0]     mem_waddr, mem_raddr;
   logic                mem_we, mem_re;

   // Results
   logic [1:0] res_color_ff;
   logic       res_drawn_ff;
   logic       rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [1:0] rsp_color_ff;
   logic       rsp_drawn_ff;

   assign req_channel.ready   = (state_ff == ptg_pkg::ST_IDLE);
   assign req_take            = req_channel.valid && (state_ff == ptg_pkg::ST_IDLE);
   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.pixel_color = rsp_color_ff;
   assign rsp_channel.drawn       = rsp_drawn_ff;

   // Coordinate magnitudes
   assign mag_x = req_channel.point_x[ptg_pkg::COORD_WIDTH-1]
                  ? (~$unsigned(req_channel.point_x) + 32'd1) : $unsigned(req_channel.point_x);
   assign mag_y = req_channel.point_y[ptg_pkg::COORD_WIDTH-1]
                  ? (~$unsigned(req_channel.point_y) + 32'd1) : $unsigned(req_channel.point_y);

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         ptg_pkg::ST_SQ_X: begin
            mul_a = mx_ff;
            mul_b = mx_ff;
         end
         ptg_pkg::ST_SQ_Y: begin
            mul_a = my_ff;
            mul_b = my_ff;
         end
         ptg_pkg::ST_SQ_LIM: begin
            mul_a = range_limit_ff;
            mul_b = range_limit_ff;
         end
         ptg_pkg::ST_SCALE_X: begin
            mul_a = mx_ff;
            mul_b = {8'd0, pixels_per_unit_ff};
         end
         ptg_pkg::ST_SCALE_Y: begin
            mul_a = my_ff;
            mul_b = {8'd0, pixels_per_unit_ff};
         end
         default: begin
            mul_a = mx_ff;
            mul_b = my_ff;
         end
      endcase
   end

   // Map scaled product to an index: trunc(+-prod + HALF) toward zero
   always_comb begin
      map_hi   = prod_ff[55:32];
      map_frac = |prod_ff[31:0];
      map_neg  = (state_ff == ptg_pkg::ST_SCALE_Y) ? nx_ff : ny_ff;
      half_w   = MW'(HALF);
      hi_w     = {1'b0, map_hi};
      pos_sum  = half_w + hi_w;
      map_ok   = 1'b0;
      map_val  = '0;
      if (!map_neg) begin
         map_ok  = (pos_sum < MW'(CANVAS_SIDE));
         map_val = pos_sum;
      end else if (hi_w < half_w) begin
         map_ok  = 1'b1;
         map_val = half_w - hi_w - MW'(map_frac);
      end else if (hi_w == half_w) begin
         // value in (-1, 0] lands on index 0
         map_ok  = 1'b1;
         map_val = '0;
      end else begin
         map_ok  = 1'b0;
      end
   end

   assign draw_ok = in_range_ff && col_ok_ff && row_ok_ff;

   // Clipped square bounds and column mask
   always_comb begin
      half_side = (op_ff == ptg_pkg::OP_ROAD) ? SW'(ROAD_HALF_SIDE) : SW'(BUILDING_HALF_SIDE);
      col_w     = SW'(col_ff);
      row_w     = SW'(row_ff);
      c_lo = (col_w >= half_side) ? (col_w - half_side) : '0;
      c_hi = ((col_w + half_side) < SW'(CANVAS_SIDE)) ? (col_w + half_side)
                                                       : SW'(CANVAS_SIDE - 1);
      r_lo = (row_w >= half_side) ? (row_w - half_side) : '0;
      r_hi = ((row_w + half_side) < SW'(CANVAS_SIDE)) ? (row_w + half_side)
                                                       : SW'(CANVAS_SIDE - 1);
      for (int c = 0; c < CANVAS_SIDE; c++) begin
         mask_in[c] = (SW'(c) >= c_lo) && (SW'(c) <= c_hi);
      end
   end

   // Row merge for the read-modify-write
   always_comb begin
      for (int c = 0; c < CANVAS_SIDE; c++) begin
         fill_row[2*c +: 2] = mask_ff[c] ? code_ff : rd_data_ff[2*c +: 2];
      end
   end

   // Next state and memory control
   always_comb begin
      state_in   = state_ff;
      row_cnt_in = row_cnt_ff;
      pend_in    = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = row_cnt_ff[IDXW-1:0];
      mem_wdata  = '0;
      mem_re     = 1'b0;
      mem_raddr  = row_cnt_ff[IDXW-1:0];
      rsp_load   = 1'b0;
      case (state_ff)
         ptg_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            row_cnt_in = row_cnt_ff + CNTW'(1);
            if (row_cnt_ff == CNTW'(CANVAS_SIDE - 1)) begin
               state_in = clear_rsp_ff ? ptg_pkg::ST_RESP : ptg_pkg::ST_IDLE;
            end
         end
         ptg_pkg::ST_IDLE: begin
            if (req_channel.valid) begin
               case (ptg_pkg::operation_type'(req_channel.operation))
                  ptg_pkg::OP_CLEAR: begin
                     state_in   = ptg_pkg::ST_CLEAR;
                     row_cnt_in = '0;
                  end
                  ptg_pkg::OP_ROAD:     state_in = ptg_pkg::ST_SQ_X;
                  ptg_pkg::OP_BUILDING: state_in = ptg_pkg::ST_SQ_X;
                  ptg_pkg::OP_READ:     state_in = ptg_pkg::ST_READ;
                  default:              state_in = ptg_pkg::ST_IDLE;
               endcase
            end
         end
         ptg_pkg::ST_SQ_X:    state_in = ptg_pkg::ST_SQ_Y;
         ptg_pkg::ST_SQ_Y:    state_in = ptg_pkg::ST_SQ_LIM;
         ptg_pkg::ST_SQ_LIM:  state_in = ptg_pkg::ST_SCALE_X;
         ptg_pkg::ST_SCALE_X: state_in = ptg_pkg::ST_SCALE_Y;
         ptg_pkg::ST_SCALE_Y: state_in = ptg_pkg::ST_MAP_Y;
         ptg_pkg::ST_MAP_Y:   state_in = ptg_pkg::ST_MASK;
         ptg_pkg::ST_MASK: begin
            if (draw_ok) begin
               state_in   = ptg_pkg::ST_FILL;
               row_cnt_in = r_lo[CNTW-1:0];
            end else begin
               state_in = ptg_pkg::ST_RESP;
            end
         end
         ptg_pkg::ST_FILL: begin
            // read row n while writing back row n-1
            if (row_cnt_ff <= row_end_ff) begin
               mem_re     = 1'b1;
               pend_in    = 1'b1;
               row_cnt_in = row_cnt_ff + CNTW'(1);
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_row_ff;
               mem_wdata = fill_row;
            end
            if ((row_cnt_ff > row_end_ff) && !pend_ff) begin
               state_in = ptg_pkg::ST_RESP;
            end
         end
         ptg_pkg::ST_READ: begin
            mem_re    = read_ok_ff;
            mem_raddr = rd_row_ff;
            state_in  = ptg_pkg::ST_PICK;
         end
         ptg_pkg::ST_PICK: state_in = ptg_pkg::ST_RESP;
         ptg_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_load = 1'b1;
               state_in = ptg_pkg::ST_IDLE;
            end
         end
         default: state_in = ptg_pkg::ST_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_channel.ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ptg_pkg::ST_CLEAR;
         row_cnt_ff         <= '0;
         pend_ff            <= 1'b0;
         clear_rsp_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         range_limit_ff     <= ptg_pkg::RANGE_LIMIT_RESET;
         pixels_per_unit_ff <= ptg_pkg::PIXELS_PER_UNIT_RESET;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            clear_rsp_ff <= (ptg_pkg::operation_type'(req_channel.operation)
                             == ptg_pkg::OP_CLEAR);
         end
         if (csr_write_enable) begin
            case (csr_index)
               ptg_pkg::CSR_RANGE_LIMIT:
                  range_limit_ff <= csr_write_data;
               ptg_pkg::CSR_PIXELS_PER_UNIT:
                  pixels_per_unit_ff <= csr_write_data[ptg_pkg::SCALE_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      pend_row_ff <= row_cnt_ff[IDXW-1:0];
      if (req_take) begin
         op_ff        <= ptg_pkg::operation_type'(req_channel.operation);
         mx_ff        <= mag_x;
         my_ff        <= mag_y;
         nx_ff        <= req_channel.point_x[ptg_pkg::COORD_WIDTH-1];
         ny_ff        <= req_channel.point_y[ptg_pkg::COORD_WIDTH-1];
         code_ff      <= (ptg_pkg::operation_type'(req_channel.operation) == ptg_pkg::OP_ROAD)
                         ? ptg_pkg::CODE_RED : ptg_pkg::CODE_BLACK;
         read_ok_ff   <= (int'(req_channel.read_row) < CANVAS_SIDE)
                         && (int'(req_channel.read_col) < CANVAS_SIDE);
         rd_row_ff    <= IDXW'(req_channel.read_row);
         pick_col_ff  <= IDXW'(CANVAS_SIDE - 1) - IDXW'(req_channel.read_col);
         res_color_ff <= ptg_pkg::CODE_WHITE;
         res_drawn_ff <= 1'b0;
      end
      case (state_ff)
         ptg_pkg::ST_SQ_Y:    dist_ff <= prod_ff;
         ptg_pkg::ST_SQ_LIM:  dist_ff <= dist_ff + prod_ff;
         ptg_pkg::ST_SCALE_X: in_range_ff <= (dist_ff <= prod_ff);
         ptg_pkg::ST_SCALE_Y: begin
            col_ff    <= map_val[IDXW-1:0];
            col_ok_ff <= map_ok;
         end
         ptg_pkg::ST_MAP_Y: begin
            row_ff    <= map_val[IDXW-1:0];
            row_ok_ff <= map_ok;
         end
         ptg_pkg::ST_MASK: begin
            mask_ff      <= mask_in;
            row_end_ff   <= r_hi[CNTW-1:0];
            res_drawn_ff <= draw_ok;
         end
         ptg_pkg::ST_PICK: begin
            res_color_ff <= read_ok_ff ? rd_data_ff[{pick_col_ff, 1'b0} +: 2]
                                       : ptg_pkg::CODE_WHITE;
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_color_ff <= res_color_ff;
         rsp_drawn_ff <= res_drawn_ff;
      end
   end

   // Canvas memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= canvas_mem[mem_raddr];
      end
   end

endmodule
